FILE: rtl/core/lbsf_pkg.sv
// ----------------------------------------------------------------------------
// lbsf_pkg
// Shared types, constants and the slew helper of the breathing slew fader.
// ----------------------------------------------------------------------------
package lbsf_pkg;

    localparam int unsigned LevelWidth = 8;
    localparam int unsigned PhaseWidth = 3;
    localparam int unsigned TimeWidth  = 32;
    localparam int unsigned AddrWidth  = 3;
    localparam int unsigned OutWidth   = 40;

    localparam logic [TimeWidth-1:0]  HoldHighMs = 32'd500;
    localparam logic [TimeWidth-1:0]  HoldLowMs  = 32'd1500;
    localparam logic [LevelWidth-1:0] ColorStep  = 8'd6;
    localparam logic [LevelWidth-1:0] NormalStep = 8'd6;
    localparam logic [LevelWidth-1:0] RiseStep   = 8'd4;
    localparam logic [LevelWidth-1:0] FallStep   = 8'd2;

    // Operating modes. The unused code behaves like idle.
    localparam logic [1:0] ModeBreath = 2'd0;
    localparam logic [1:0] ModeNormal = 2'd1;
    localparam logic [1:0] ModeIdle   = 2'd2;

    // Register indexes on the configuration port.
    localparam logic [AddrWidth-1:0] RegMode           = 3'd0;
    localparam logic [AddrWidth-1:0] RegGoalRed        = 3'd1;
    localparam logic [AddrWidth-1:0] RegGoalGreen      = 3'd2;
    localparam logic [AddrWidth-1:0] RegGoalBlue       = 3'd3;
    localparam logic [AddrWidth-1:0] RegGoalBrightness = 3'd4;
    localparam logic [AddrWidth-1:0] RegBreathLow      = 3'd5;
    localparam logic [AddrWidth-1:0] RegBreathHigh     = 3'd6;

    localparam logic [LevelWidth-1:0] BreathLowReset  = 8'd32;
    localparam logic [LevelWidth-1:0] BreathHighReset = 8'd128;

    // Breath phases.
    localparam logic [PhaseWidth-1:0] PhaseRise     = 3'd0;
    localparam logic [PhaseWidth-1:0] PhaseHoldHigh = 3'd1;
    localparam logic [PhaseWidth-1:0] PhaseFall     = 3'd2;
    localparam logic [PhaseWidth-1:0] PhaseHoldLow  = 3'd3;
    localparam logic [PhaseWidth-1:0] PhaseRestart  = 3'd4;

    typedef struct packed {
        logic [1:0]            mode;
        logic [LevelWidth-1:0] goal_red;
        logic [LevelWidth-1:0] goal_green;
        logic [LevelWidth-1:0] goal_blue;
        logic [LevelWidth-1:0] goal_brightness;
        logic [LevelWidth-1:0] breath_low;
        logic [LevelWidth-1:0] breath_high;
    } cfg_t;

    typedef struct packed {
        logic [LevelWidth-1:0] brightness;
        logic [LevelWidth-1:0] red;
        logic [LevelWidth-1:0] green;
        logic [LevelWidth-1:0] blue;
        logic [PhaseWidth-1:0] phase;
        logic [TimeWidth-1:0]  hold_start;
    } fade_state_t;

    // Moves cur toward goal by at most step.
    function automatic logic [LevelWidth-1:0] slew(
        input logic [LevelWidth-1:0] cur,
        input logic [LevelWidth-1:0] goal,
        input logic [LevelWidth-1:0] step
    );
        logic [LevelWidth-1:0] result;
        result = goal;
        if (goal > cur && (goal - cur) > step) begin
            result = cur + step;
        end else if (cur > goal && (cur - goal) > step) begin
            result = cur - step;
        end
        return result;
    endfunction

endpackage

FILE: rtl/core/lbsf_cfg_regs.sv
// ----------------------------------------------------------------------------
// lbsf_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
module lbsf_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lbsf_pkg::AddrWidth-1:0]     cfg_addr,
    input  logic [lbsf_pkg::LevelWidth-1:0]    cfg_wdata,
    output lbsf_pkg::cfg_t                     cfg
);

    lbsf_pkg::cfg_t cfg_reg;
    lbsf_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_addr)
                lbsf_pkg::RegMode:           cfg_next.mode            = cfg_wdata[1:0];
                lbsf_pkg::RegGoalRed:        cfg_next.goal_red        = cfg_wdata;
                lbsf_pkg::RegGoalGreen:      cfg_next.goal_green      = cfg_wdata;
                lbsf_pkg::RegGoalBlue:       cfg_next.goal_blue       = cfg_wdata;
                lbsf_pkg::RegGoalBrightness: cfg_next.goal_brightness = cfg_wdata;
                lbsf_pkg::RegBreathLow:      cfg_next.breath_low      = cfg_wdata;
                lbsf_pkg::RegBreathHigh:     cfg_next.breath_high     = cfg_wdata;
                default:                     cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.mode            <= lbsf_pkg::ModeIdle;
            cfg_reg.goal_red        <= '0;
            cfg_reg.goal_green      <= '0;
            cfg_reg.goal_blue       <= '0;
            cfg_reg.goal_brightness <= '0;
            cfg_reg.breath_low      <= lbsf_pkg::BreathLowReset;
            cfg_reg.breath_high     <= lbsf_pkg::BreathHighReset;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

FILE: rtl/core/lbsf_update.sv
// ----------------------------------------------------------------------------
// lbsf_update
// Next-state logic for one tick: color slew, normal slew and breath phases.
// ----------------------------------------------------------------------------
module lbsf_update (
    input  lbsf_pkg::cfg_t                     cfg,
    input  lbsf_pkg::fade_state_t              cur,
    input  logic [lbsf_pkg::TimeWidth-1:0]     now_ms,
    output lbsf_pkg::fade_state_t              nxt
);

    logic [lbsf_pkg::TimeWidth-1:0]  elapsed;
    logic [lbsf_pkg::LevelWidth-1:0] rise_level;
    logic [lbsf_pkg::LevelWidth-1:0] fall_level;

    // Elapsed time wraps with the free-running millisecond counter.
    assign elapsed    = now_ms - cur.hold_start;
    assign rise_level = lbsf_pkg::slew(cur.brightness, cfg.breath_high, lbsf_pkg::RiseStep);
    assign fall_level = lbsf_pkg::slew(cur.brightness, cfg.breath_low, lbsf_pkg::FallStep);

    always_comb begin
        nxt = cur;
        case (cfg.mode)
            lbsf_pkg::ModeBreath: begin
                nxt.red   = lbsf_pkg::slew(cur.red, cfg.goal_red, lbsf_pkg::ColorStep);
                nxt.green = lbsf_pkg::slew(cur.green, cfg.goal_green, lbsf_pkg::ColorStep);
                nxt.blue  = lbsf_pkg::slew(cur.blue, cfg.goal_blue, lbsf_pkg::ColorStep);
                case (cur.phase)
                    lbsf_pkg::PhaseRise: begin
                        nxt.brightness = rise_level;
                        if (rise_level == cfg.breath_high) begin
                            nxt.hold_start = now_ms;
                            nxt.phase      = lbsf_pkg::PhaseHoldHigh;
                        end
                    end
                    lbsf_pkg::PhaseHoldHigh: begin
                        if (elapsed > lbsf_pkg::HoldHighMs) begin
                            nxt.phase = lbsf_pkg::PhaseFall;
                        end
                    end
                    lbsf_pkg::PhaseFall: begin
                        nxt.brightness = fall_level;
                        if (fall_level == cfg.breath_low) begin
                            nxt.hold_start = now_ms;
                            nxt.phase      = lbsf_pkg::PhaseHoldLow;
                        end
                    end
                    lbsf_pkg::PhaseHoldLow: begin
                        if (elapsed > lbsf_pkg::HoldLowMs) begin
                            nxt.phase = lbsf_pkg::PhaseRestart;
                        end
                    end
                    default: begin
                        // Restart, and any code past it, returns to the rise.
                        nxt.phase = lbsf_pkg::PhaseRise;
                    end
                endcase
            end
            lbsf_pkg::ModeNormal: begin
                nxt.red   = lbsf_pkg::slew(cur.red, cfg.goal_red, lbsf_pkg::ColorStep);
                nxt.green = lbsf_pkg::slew(cur.green, cfg.goal_green, lbsf_pkg::ColorStep);
                nxt.blue  = lbsf_pkg::slew(cur.blue, cfg.goal_blue, lbsf_pkg::ColorStep);
                nxt.brightness = lbsf_pkg::slew(cur.brightness, cfg.goal_brightness,
                                                lbsf_pkg::NormalStep);
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

endmodule

FILE: rtl/core/led_breath_slew_fader.sv
// ----------------------------------------------------------------------------
// led_breath_slew_fader
// Per-tick LED color slew with a timed breathing brightness envelope.
// ----------------------------------------------------------------------------
// Each input transaction on the s_ channel is one update tick carrying the
// current millisecond time. The block updates its color levels, brightness
// and breath phase from that tick and presents exactly one result
// transaction on the m_ channel.
// Latency: the result is valid in the cycle after the tick is accepted.
// Throughput: one tick per cycle while the receiver does not stall; the single
// pass of next-state logic from the state registers back into them sets this figure.
// A new tick is taken while the previous result is being taken in the same
// cycle; while the receiver stalls with a result held, s_tready is low and
// the held result stays unchanged.
// Configuration is written through cfg_we / cfg_addr / cfg_wdata, one
// register per cycle, by the user only while no tick is in flight; the block does not enforce it.
// Reset (aresetn low, synchronous) clears levels, phase and hold time,
// empties the result register and sets mode to idle, floor 32, ceiling 128.
// ----------------------------------------------------------------------------
module led_breath_slew_fader (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [lbsf_pkg::AddrWidth-1:0]      cfg_addr,
    input  logic [lbsf_pkg::LevelWidth-1:0]     cfg_wdata,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lbsf_pkg::TimeWidth-1:0]      s_tdata,   // [31:0] now_ms
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [7:0] out_brightness, [15:8] out_red, [23:16] out_green,
    // [31:24] out_blue, [34:32] out_phase, [39:35] zero
    output logic [lbsf_pkg::OutWidth-1:0]       m_tdata
);

    lbsf_pkg::cfg_t        cfg;
    lbsf_pkg::fade_state_t state_reg;
    lbsf_pkg::fade_state_t state_next;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic                  accept;

    lbsf_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lbsf_update u_update (
        .cfg    (cfg),
        .cur    (state_reg),
        .now_ms (s_tdata),
        .nxt    (state_next)
    );

    assign s_tready      = !m_tvalid_reg || m_tready;
    assign accept        = s_tvalid && s_tready;
    assign m_tvalid_next = accept ? 1'b1 : (m_tvalid_reg && !m_tready);

    // The state registers double as the result register: the result of a
    // tick is the state it leaves behind.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
            if (accept) begin
                state_reg <= state_next;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'd0, state_reg.phase, state_reg.blue, state_reg.green,
                       state_reg.red, state_reg.brightness};

endmodule

FILE: rtl/core/lbsf_checker.sv
// ----------------------------------------------------------------------------
// lbsf_checker
// Port-level checks of the breathing slew fader, bound to the top level.
// ----------------------------------------------------------------------------
module lbsf_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    input  logic                                s_tready,
    input  logic                                m_tvalid,
    input  logic                                m_tready,
    input  logic [lbsf_pkg::OutWidth-1:0]       m_tdata
);

    // Every accepted tick yields a result in the next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("accepted tick produced no result");

    // The breath phase never leaves the five defined phases.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:32] <= lbsf_pkg::PhaseRestart))
        else $error("breath phase out of range");

    // A stalled result keeps its data.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("stalled result changed");

    // A stalled result is not withdrawn.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("stalled result dropped");

endmodule

bind led_breath_slew_fader lbsf_checker u_lbsf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
